// ===== rtl/lrk_pkg.sv =====
// Package for the LRU-K page replacer: sizes, request and status codes,
// and the structs between the table sequencer and the victim selector.
// No dependencies.
package lrk_pkg;

    localparam int TBL_FRAMES = 16;
    localparam int MAX_K      = 4;
    localparam int TIME_BITS  = 32;

    // fixed field widths of the channels and the configuration port
    localparam int REQ_W      = 2;
    localparam int FRAME_W    = 4;
    localparam int STATUS_W   = 3;
    localparam int CNT_W      = 5;
    localparam int FIU_W      = 5;
    localparam int DEPTH_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // derived sizes
    localparam int IDX_W  = $clog2(TBL_FRAMES);
    localparam int SLOT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int FILL_W = $clog2(MAX_K + 1);
    localparam int TOT_W  = $clog2(TBL_FRAMES + 1);
    localparam int HIST_DEPTH = TBL_FRAMES * MAX_K;
    localparam int HADDR_W    = $clog2(HIST_DEPTH);

    localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SETEV  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_EVICT  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONEVICT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOVICTIM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUST  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 1'd1;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic             vld;
        logic             full;
        logic [IDX_W-1:0] idx;
        t_time            ts;
    } t_cand;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_best;

    // K clamped to 1..MAX_K
    function automatic logic [FILL_W-1:0] eff_k(input logic [DEPTH_W-1:0] d);
        logic [FILL_W-1:0] k;
        if (d == '0) begin
            k = FILL_W'(1);
        end else if (int'(d) > MAX_K) begin
            k = FILL_W'(MAX_K);
        end else begin
            k = FILL_W'(d);
        end
        return k;
    endfunction

endpackage

// ===== rtl/lrk_req_if.sv =====
// Request channel of the LRU-K page replacer.
// Depends on lrk_pkg.
interface lrk_req_if;
    import lrk_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [FRAME_W-1:0] frame;
    logic               evictable_flag;

    modport source (output valid, req_type, frame, evictable_flag, input ready);
    modport sink   (input valid, req_type, frame, evictable_flag, output ready);
endinterface

// ===== rtl/lrk_rsp_if.sv =====
// Response channel of the LRU-K page replacer.
// Depends on lrk_pkg.
interface lrk_rsp_if;
    import lrk_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                victim_valid;
    logic [FRAME_W-1:0]  victim_frame;
    logic [CNT_W-1:0]    evictable_count;

    modport source (output valid, status, victim_valid, victim_frame, evictable_count,
                    input ready);
    modport sink   (input valid, status, victim_valid, victim_frame, evictable_count,
                    output ready);
endinterface

// ===== rtl/lrk_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lrk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/lrk_victim_sel.sv =====
// Victim selector: one timestamp comparator that keeps the best candidate
// seen so far during an evict scan. Depends on lrk_pkg.
module lrk_victim_sel (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clr,
    input  lrk_pkg::t_cand i_cand,
    output lrk_pkg::t_best o_best
);
    import lrk_pkg::*;

    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic             r_full;
    t_time            r_ts;
    logic             n_found;
    logic [IDX_W-1:0] n_idx;
    logic             n_full;
    t_time            n_ts;
    logic             beats;

    // not-full frames go first; then the older timestamp, ties keep the lower id
    assign beats = (i_cand.full != r_full) ? !i_cand.full : (i_cand.ts < r_ts);

    always_comb begin
        n_found = r_found;
        n_idx   = r_idx;
        n_full  = r_full;
        n_ts    = r_ts;
        if (i_clr) begin
            n_found = 1'b0;
        end else if (i_cand.vld && (!r_found || beats)) begin
            n_found = 1'b1;
            n_idx   = i_cand.idx;
            n_full  = i_cand.full;
            n_ts    = i_cand.ts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
        r_idx  <= n_idx;
        r_full <= n_full;
        r_ts   <= n_ts;
    end

    assign o_best.found = r_found;
    assign o_best.idx   = r_idx;
endmodule

// ===== rtl/lru_k_page_replacer_top.sv =====
// LRU-K page replacer top level: frame table, history RAM, sequencer.
// Depends on lrk_pkg, lrk_req_if, lrk_rsp_if, lrk_ram, lrk_victim_sel.
//
// Usage:
//   i_req carries one request item (access, set evictable, remove, evict);
//   o_rsp returns exactly one response item per request, in order.
//   i_cfg_we/i_cfg_idx/i_cfg_data write frames_in_use (index 0) and
//   history_depth (index 1); write only while no request is in flight.
//   Access, set evictable and remove update the table when accepted; the
//   result is registered and copied to the output register from DONE.
//   Evict walks every frame through one shared comparator, one frame per
//   cycle, fed by the single read port of the history RAM; after the scan
//   the EVFIN state removes the victim, if any, and DONE loads the
//   response. The next request is accepted once the sequencer is idle again.
//   One request is worked on at a time; i_req.ready is high only when idle.
//   A response sits in an output register; if o_rsp is stalled, the next
//   request is still accepted and processed, and its response waits until
//   the output register frees up; i_req.ready stays low meanwhile.
//   Reset (synchronous, active low) empties the table, clears the time
//   counter and restores frames_in_use = 16 and history_depth = 2.
//   No clearing pass: history entries are only read once written.
module lru_k_page_replacer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lrk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lrk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lrk_req_if.sink                       i_req,
    lrk_rsp_if.source                     o_rsp
);
    import lrk_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_EVFIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [FIU_W-1:0]    r_fiu;
    logic [DEPTH_W-1:0]  r_depth;
    logic [TBL_FRAMES-1:0] r_present, n_present;
    logic [TBL_FRAMES-1:0] r_evict, n_evict;
    logic [FILL_W-1:0]   r_fill [TBL_FRAMES];
    logic [FILL_W-1:0]   n_fill [TBL_FRAMES];
    logic [SLOT_W-1:0]   r_head [TBL_FRAMES];
    logic [SLOT_W-1:0]   n_head [TBL_FRAMES];
    t_time               r_time, n_time;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [IDX_W:0]      r_idx, n_idx;
    logic                r_c_vld, n_c_vld;
    logic                r_c_full, n_c_full;
    logic [IDX_W-1:0]    r_c_idx, n_c_idx;
    logic [STATUS_W-1:0] r_res_st, n_res_st;
    logic                r_res_vv, n_res_vv;
    logic [IDX_W-1:0]    r_res_vf, n_res_vf;
    logic                r_out_vld, n_out_vld;
    logic [STATUS_W-1:0] r_out_st;
    logic                r_out_vv;
    logic [FRAME_W-1:0]  r_out_vf;
    logic [CNT_W-1:0]    r_out_cnt;

    logic                in_fire;
    logic                out_free;
    logic                load_out;
    logic [IDX_W-1:0]    fidx;
    logic                frame_ok;
    logic [FILL_W-1:0]   k;
    logic                cur_full;
    logic [FILL_W-1:0]   off;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   rd_slot;
    logic [SLOT_W-1:0]   new_head;
    logic                ram_we;
    logic [HADDR_W-1:0]  ram_waddr;
    logic [HADDR_W-1:0]  ram_raddr;
    t_time               ram_rdata;
    logic                sel_clr;
    t_cand               cand;
    t_best               best;

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_free = !r_out_vld || o_rsp.ready;
    assign load_out = (r_state == S_DONE) && out_free;
    assign k        = eff_k(r_depth);

    // one frame index serves the table in every state
    always_comb begin
        case (r_state)
            S_SCAN:  fidx = r_idx[IDX_W-1:0];
            S_EVFIN: fidx = best.idx;
            default: fidx = IDX_W'(i_req.frame);
        endcase
    end

    assign frame_ok = (FIU_W'(i_req.frame) < r_fiu) && (int'(i_req.frame) < TBL_FRAMES);

    // history is a ring per frame; head holds the newest access
    assign cur_full = r_fill[fidx] >= k;
    assign off      = cur_full ? (k - FILL_W'(1)) : (r_fill[fidx] - FILL_W'(1));
    assign slot_sum = {1'b0, r_head[fidx]} + (SLOT_W + 1)'(off);
    assign rd_slot  = (int'(slot_sum) >= MAX_K) ? SLOT_W'(int'(slot_sum) - MAX_K)
                                                : SLOT_W'(slot_sum);
    assign new_head = (r_head[fidx] == '0) ? SLOT_W'(MAX_K - 1)
                                           : (r_head[fidx] - SLOT_W'(1));

    assign ram_waddr = HADDR_W'(fidx) * HADDR_W'(MAX_K) + HADDR_W'(new_head);
    assign ram_raddr = HADDR_W'(fidx) * HADDR_W'(MAX_K) + HADDR_W'(rd_slot);

    always_comb begin
        n_state   = r_state;
        n_present = r_present;
        n_evict   = r_evict;
        n_fill    = r_fill;
        n_head    = r_head;
        n_time    = r_time;
        n_total   = r_total;
        n_idx     = r_idx;
        n_c_vld   = 1'b0;
        n_c_full  = cur_full;
        n_c_idx   = fidx;
        n_res_st  = r_res_st;
        n_res_vv  = r_res_vv;
        n_res_vf  = r_res_vf;
        ram_we    = 1'b0;
        sel_clr   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res_st = ST_OK;
                    n_res_vv = 1'b0;
                    n_res_vf = '0;
                    n_state  = S_DONE;
                    if (i_req.req_type == REQ_EVICT) begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        sel_clr = 1'b1;
                    end else if (!frame_ok) begin
                        n_res_st = ST_RANGE;
                    end else begin
                        case (i_req.req_type)
                            REQ_ACCESS: begin
                                if (r_time == '1) begin
                                    n_res_st = ST_EXHAUST;
                                end else begin
                                    n_time            = r_time + t_time'(1);
                                    ram_we            = 1'b1;
                                    n_present[fidx]   = 1'b1;
                                    n_head[fidx]      = new_head;
                                    if (!r_present[fidx]) begin
                                        n_fill[fidx] = FILL_W'(1);
                                    end else if (int'(r_fill[fidx]) < MAX_K) begin
                                        n_fill[fidx] = r_fill[fidx] + FILL_W'(1);
                                    end
                                end
                            end
                            REQ_SETEV: begin
                                if (r_present[fidx]) begin
                                    if (r_evict[fidx] && !i_req.evictable_flag) begin
                                        n_total = r_total - TOT_W'(1);
                                    end else if (!r_evict[fidx] && i_req.evictable_flag) begin
                                        n_total = r_total + TOT_W'(1);
                                    end
                                    n_evict[fidx] = i_req.evictable_flag;
                                end
                            end
                            default: begin
                                if (r_present[fidx]) begin
                                    if (r_evict[fidx]) begin
                                        n_present[fidx] = 1'b0;
                                        n_evict[fidx]   = 1'b0;
                                        n_fill[fidx]    = '0;
                                        n_total         = r_total - TOT_W'(1);
                                    end else begin
                                        n_res_st = ST_NONEVICT;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (int'(r_idx) < TBL_FRAMES) begin
                    n_c_vld = r_present[fidx] && r_evict[fidx];
                    n_idx   = r_idx + (IDX_W + 1)'(1);
                end else begin
                    n_state = S_EVFIN;
                end
            end
            S_EVFIN: begin
                n_state = S_DONE;
                if (best.found) begin
                    n_present[fidx] = 1'b0;
                    n_evict[fidx]   = 1'b0;
                    n_fill[fidx]    = '0;
                    n_total         = r_total - TOT_W'(1);
                    n_res_vv        = 1'b1;
                    n_res_vf        = best.idx;
                end else begin
                    n_res_st = ST_NOVICTIM;
                end
            end
            default: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fiu     <= FIU_W'(16);
            r_depth   <= DEPTH_W'(2);
            r_present <= '0;
            r_evict   <= '0;
            r_fill    <= '{default: '0};
            r_head    <= '{default: '0};
            r_time    <= '0;
            r_total   <= '0;
            r_idx     <= '0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_evict   <= n_evict;
            r_fill    <= n_fill;
            r_head    <= n_head;
            r_time    <= n_time;
            r_total   <= n_total;
            r_idx     <= n_idx;
            r_c_vld   <= n_c_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we && i_cfg_idx == CFG_FRAMES) begin
                r_fiu <= FIU_W'(i_cfg_data);
            end
            if (i_cfg_we && i_cfg_idx == CFG_DEPTH) begin
                r_depth <= DEPTH_W'(i_cfg_data);
            end
        end
        r_c_full <= n_c_full;
        r_c_idx  <= n_c_idx;
        r_res_st <= n_res_st;
        r_res_vv <= n_res_vv;
        r_res_vf <= n_res_vf;
        if (load_out) begin
            r_out_st  <= r_res_st;
            r_out_vv  <= r_res_vv;
            r_out_vf  <= FRAME_W'(r_res_vf);
            r_out_cnt <= CNT_W'(r_total);
        end
    end

    lrk_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (n_time),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cand.vld  = r_c_vld;
    assign cand.full = r_c_full;
    assign cand.idx  = r_c_idx;
    assign cand.ts   = ram_rdata;

    lrk_victim_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (sel_clr),
        .i_cand  (cand),
        .o_best  (best)
    );

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_out_st;
    assign o_rsp.victim_valid    = r_out_vv;
    assign o_rsp.victim_frame    = r_out_vf;
    assign o_rsp.evictable_count = r_out_cnt;

    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present & r_evict) == int'(r_total))
        else $error("evictable total out of step with table");

    a_evict_needs_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evict & ~r_present) == '0)
        else $error("evictable mark on absent frame");

    a_victim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_vv) |-> (r_out_st == ST_OK))
        else $error("victim reported with error status");

    a_evict_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.req_type == REQ_EVICT) |=> (r_state == S_SCAN))
        else $error("evict request did not start a scan");

    a_no_cand_outside_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !r_c_vld)
        else $error("scan candidate outside of a scan");
endmodule

// ===== test/tb_lru_k_page_replacer_top.sv =====
// Self-checking testbench for lru_k_page_replacer_top: directed table, then random phases
// under several register settings, each response checked against an in-bench LRU-K table
// or a directed row's values. Depends on lrk_pkg, lrk_req_if, lrk_rsp_if, replacer RTL.
module tb_lru_k_page_replacer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lrk_pkg::*;

    localparam int  N_PHASES   = 12;
    localparam int  PHASE_LEN  = 100;
    localparam int  LONG_HOLD  = 300;
    localparam int  DRAIN      = 40;
    localparam time RUN_LIMIT  = 20_000_000;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [FRAME_W-1:0] frame;
        logic               flag;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                vv;
        logic [FRAME_W-1:0]  vf;
        logic [CNT_W-1:0]    cnt;
    } t_rsp;

    typedef struct packed {
        logic typed;
        t_rsp rsp;
    } t_note;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        t_req                   req;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        t_rsp                   rsp;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    lrk_req_if req_ch();
    lrk_rsp_if rsp_ch();

    lru_k_page_replacer_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #10 clk = ~clk;

    // LRU-K table mirror
    logic [FIU_W-1:0]   tbl_fiu;
    logic [DEPTH_W-1:0] tbl_depth;
    bit                 tbl_present [TBL_FRAMES];
    bit                 tbl_evict   [TBL_FRAMES];
    t_time              tbl_hist    [TBL_FRAMES][MAX_K];
    int unsigned        tbl_fill    [TBL_FRAMES];
    t_time              tbl_clock;
    int unsigned        tbl_evcount;

    t_note note_q [$];
    t_rsp  pending_rsp [$];

    int unsigned n_sent, n_done, n_err, n_victims, n_err_status, n_settings;
    bit hold_sink, sink_steady, src_steady;

    t_row plan [32];

    function automatic void drop_frame(int f);
        if (tbl_evict[f] && tbl_evcount > 0) tbl_evcount--;
        tbl_present[f] = 1'b0;
        tbl_evict[f]   = 1'b0;
        tbl_fill[f]    = 0;
    endfunction

    // true when frame a goes out before frame b
    function automatic bit goes_first(int a, int b, int unsigned k);
        bit    a_full, b_full;
        t_time ta, tb;
        a_full = tbl_fill[a] >= k;
        b_full = tbl_fill[b] >= k;
        if (a_full != b_full) return !a_full;
        ta = a_full ? tbl_hist[a][k-1] : tbl_hist[a][tbl_fill[a]-1];
        tb = b_full ? tbl_hist[b][k-1] : tbl_hist[b][tbl_fill[b]-1];
        return ta < tb;
    endfunction

    function automatic t_rsp replacer_step(t_req r);
        t_rsp        o;
        int unsigned k;
        int          best, f;
        bit          found;
        o = '0;
        k = (tbl_depth == 0) ? 1 : (int'(tbl_depth) > MAX_K) ? MAX_K : tbl_depth;
        f = r.frame;
        if (r.kind == REQ_EVICT) begin
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < TBL_FRAMES; i++) begin
                if (tbl_present[i] && tbl_evict[i]) begin
                    if (!found || goes_first(i, best, k)) best = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                drop_frame(best);
                o.vv = 1'b1;
                o.vf = FRAME_W'(best);
            end else begin
                o.status = ST_NOVICTIM;
            end
        end else if (FIU_W'(r.frame) >= tbl_fiu) begin
            o.status = ST_RANGE;
        end else if (r.kind == REQ_ACCESS) begin
            if (tbl_clock == '1) begin
                o.status = ST_EXHAUST;
            end else begin
                tbl_clock++;
                if (!tbl_present[f]) begin
                    tbl_present[f] = 1'b1;
                    tbl_evict[f]   = 1'b0;
                    tbl_fill[f]    = 0;
                end
                for (int j = MAX_K - 1; j > 0; j--) tbl_hist[f][j] = tbl_hist[f][j-1];
                tbl_hist[f][0] = tbl_clock;
                if (tbl_fill[f] < MAX_K) tbl_fill[f]++;
            end
        end else if (r.kind == REQ_SETEV) begin
            if (tbl_present[f]) begin
                if (tbl_evict[f] && !r.flag) tbl_evcount--;
                else if (!tbl_evict[f] && r.flag) tbl_evcount++;
                tbl_evict[f] = r.flag;
            end
        end else if (tbl_present[f]) begin
            if (tbl_evict[f]) drop_frame(f);
            else o.status = ST_NONEVICT;
        end
        o.cnt = CNT_W'(tbl_evcount);
        return o;
    endfunction

    function automatic t_row rq(logic [REQ_W-1:0] k, int f, logic fl);
        t_row r;
        r = '0;
        r.kind = ROW_REQ;
        r.req  = '{k, FRAME_W'(f), fl};
        return r;
    endfunction

    function automatic t_row rqx(logic [REQ_W-1:0] k, int f, logic fl,
                                 logic [STATUS_W-1:0] st, logic vv, int vf, int cnt);
        t_row r;
        r = rq(k, f, fl);
        r.typed = 1'b1;
        r.rsp   = '{st, vv, FRAME_W'(vf), CNT_W'(cnt)};
        return r;
    endfunction

    function automatic t_row cf(logic [CFG_IDX_W-1:0] idx, int d);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = CFG_DATA_W'(d);
        return r;
    endfunction

    function automatic t_req rand_req();
        t_req        r;
        int unsigned p, lim;
        p   = $urandom_range(0, 99);
        r.kind = (p < 40) ? REQ_ACCESS : (p < 70) ? REQ_SETEV :
                 (p < 82) ? REQ_REMOVE : REQ_EVICT;
        lim = (tbl_fiu == 0 || tbl_fiu > TBL_FRAMES) ? TBL_FRAMES : tbl_fiu;
        r.frame = ($urandom_range(0, 9) == 0) ? FRAME_W'($urandom_range(0, TBL_FRAMES - 1))
                                             : FRAME_W'($urandom_range(0, lim - 1));
        r.flag  = $urandom_range(0, 9) < 7;
        return r;
    endfunction

    task automatic send_item(input t_req r, input logic typed, input t_rsp exp_rsp);
        t_note nt;
        nt.typed = typed;
        nt.rsp   = exp_rsp;
        note_q   = {note_q, nt};
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= r.kind;
        req_ch.frame          <= r.frame;
        req_ch.evictable_flag <= r.flag;
        do @(posedge clk); while (!req_ch.ready);
        n_sent++;
    endtask

    task automatic src_gap();
        int unsigned n;
        if (!src_steady && $urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (n_done != n_sent) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge clk);
        if (idx == CFG_FRAMES) tbl_fiu = d;
        else tbl_depth = d[DEPTH_W-1:0];
        n_settings++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cmp_field(input string name, input int exp_v, input logic [7:0] act_v);
        if (act_v !== 8'(exp_v)) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            n_err++;
        end
    endtask

    // request side: predict each accepted item
    always @(posedge clk) begin
        t_note nt;
        t_rsp  p;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            nt = note_q[0];
            note_q.delete(0);
            p  = replacer_step(t_req'({req_ch.req_type, req_ch.frame, req_ch.evictable_flag}));
            pending_rsp = {pending_rsp, (nt.typed ? nt.rsp : p)};
        end
    end

    // response side
    always @(posedge clk) begin
        t_rsp e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_done++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with nothing expected, status %0d", $time,
                         rsp_ch.status);
                n_err++;
            end else begin
                e = pending_rsp[0];
                pending_rsp.delete(0);
                cmp_field("status", e.status, 8'(rsp_ch.status));
                cmp_field("victim_valid", e.vv, 8'(rsp_ch.victim_valid));
                cmp_field("victim_frame", e.vf, 8'(rsp_ch.victim_frame));
                cmp_field("evictable_count", e.cnt, 8'(rsp_ch.evictable_count));
                if (e.vv) n_victims++;
                if (e.status != ST_OK) n_err_status++;
            end
        end
    end

    // response sink with random stalls
    initial begin
        int unsigned n;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_sink) begin
                hold_sink = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!sink_steady && $urandom_range(0, 5) == 0) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 3);
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned fiu, depth;
        t_req        r;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= '0;
        cfg_data              <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_ACCESS;
        req_ch.frame          <= '0;
        req_ch.evictable_flag <= 1'b0;
        tbl_fiu     = 5'd16;
        tbl_depth   = 3'd2;
        tbl_clock   = '0;
        tbl_evcount = 0;
        foreach (tbl_present[i]) begin
            tbl_present[i] = 1'b0;
            tbl_evict[i]   = 1'b0;
            tbl_fill[i]    = 0;
        end
        n_sent = 0; n_done = 0; n_err = 0;
        n_victims = 0; n_err_status = 0; n_settings = 0;
        hold_sink = 1'b0; sink_steady = 1'b0; src_steady = 1'b0;

        plan = '{
            rqx(REQ_EVICT,  0, 0, ST_NOVICTIM, 0, 0, 0),
            rqx(REQ_ACCESS, 15, 1, ST_OK, 0, 0, 0),
            rqx(REQ_ACCESS, 0, 0, ST_OK, 0, 0, 0),
            rqx(REQ_SETEV,  0, 1, ST_OK, 0, 0, 1),
            rqx(REQ_SETEV,  15, 1, ST_OK, 0, 0, 2),
            rqx(REQ_SETEV,  7, 1, ST_OK, 0, 0, 2),     // absent frame
            rqx(REQ_REMOVE, 7, 0, ST_OK, 0, 0, 2),     // absent frame
            rqx(REQ_ACCESS, 3, 0, ST_OK, 0, 0, 2),
            rqx(REQ_REMOVE, 3, 1, ST_NONEVICT, 0, 0, 2),
            rq(REQ_ACCESS, 0, 0),
            rqx(REQ_EVICT,  9, 1, ST_OK, 1, 15, 1),    // short history beats full one
            rq(REQ_ACCESS, 3, 1),
            rq(REQ_SETEV,  3, 1),
            rq(REQ_ACCESS, 3, 0),
            rq(REQ_EVICT,  0, 0),                      // both full: oldest K-th access
            rq(REQ_REMOVE, 3, 0),
            cf(CFG_DEPTH, 0),                          // K of zero acts as one
            cf(CFG_FRAMES, 4),
            rqx(REQ_ACCESS, 4, 0, ST_RANGE, 0, 0, 0),
            rqx(REQ_SETEV,  15, 0, ST_RANGE, 0, 0, 0),
            rqx(REQ_REMOVE, 5, 1, ST_RANGE, 0, 0, 0),
            rq(REQ_ACCESS, 2, 0),
            rq(REQ_SETEV,  2, 1),
            rq(REQ_ACCESS, 1, 0),
            rq(REQ_SETEV,  1, 1),
            rq(REQ_ACCESS, 2, 1),
            rq(REQ_EVICT,  0, 0),
            cf(CFG_DEPTH, 7),                          // clamps to MAX_K
            cf(CFG_FRAMES, 31),
            cf(CFG_FRAMES, 0),
            rqx(REQ_ACCESS, 0, 0, ST_RANGE, 0, 0, 1),
            rq(REQ_EVICT,  15, 1)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_item(plan[i].req, plan[i].typed, plan[i].rsp);
                src_gap();
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin fiu = 16; depth = 4; end
                1: begin fiu = 1;  depth = 1; end
                2: begin fiu = 31; depth = 7; end
                3: begin fiu = 2;  depth = 0; end
                4: begin fiu = 0;  depth = 3; end
                default: begin
                    fiu   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(1, 16);
                    depth = $urandom_range(0, 7);
                end
            endcase
            // upper data bits are don't-care for the depth register
            write_reg(CFG_FRAMES, CFG_DATA_W'(fiu));
            write_reg(CFG_DEPTH, CFG_DATA_W'({$urandom_range(0, 3), 3'(depth)}));
            sink_steady = (p % 4 == 3);
            src_steady  = (p % 4 == 1) || p == 6 || p == 10;
            if (p == 6 || p == 10) hold_sink = 1'b1;
            for (int i = 0; i < PHASE_LEN; i++) begin
                r = rand_req();
                send_item(r, 1'b0, '0);
                src_gap();
            end
        end

        wait_idle();
        repeat (DRAIN) @(posedge clk);
        if (pending_rsp.size() != 0) begin
            $display("%0t: %0d expected responses never arrived", $time, pending_rsp.size());
            n_err++;
        end
        $display("Ran %0d requests over %0d register writes: %0d evictions, %0d error statuses",
                 n_sent, n_settings, n_victims, n_err_status);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
